@@ rtl/chm_pkg.sv @@
package chm_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_COUNT  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	// Read side of the slot table at one address.
	typedef struct packed {
		logic  used;
		logic  has_next;
		idx_t  link;
		word_t value;
	} rd_t;

	// Write requests into the slot table for one cycle.
	typedef struct packed {
		logic  set_en;
		idx_t  set_addr;
		word_t set_value;
		logic  lnk_en;
		idx_t  lnk_addr;
		idx_t  lnk_to;
		logic  clr_en;
		idx_t  clr_addr;
		logic  cut_en;
		idx_t  cut_addr;
	} wr_t;

	// Home slot: magnitude of the word modulo the table size.
	function automatic idx_t home_of(input word_t v);
		word_t mag;
		mag = v[31] ? (~v + 32'd1) : v;
		return idx_t'(mag % CAPACITY);
	endfunction

endpackage

@@ rtl/chm_table.sv @@
module chm_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chm_pkg::idx_t                 rd_addr,
	output chm_pkg::rd_t                  rd,
	output logic [chm_pkg::CAPACITY-1:0]  used,
	input  chm_pkg::wr_t                  wr,
	output chm_pkg::cnt_t                 size
);
	import chm_pkg::*;

	word_t value_mem [CAPACITY];
	idx_t  link_mem  [CAPACITY];
	logic [CAPACITY-1:0] used_q;
	logic [CAPACITY-1:0] lv_q;
	cnt_t size_q;

	always_ff @(posedge clk) begin
		if (wr.set_en) begin
			value_mem[wr.set_addr] <= wr.set_value;
		end
		if (wr.lnk_en) begin
			link_mem[wr.lnk_addr] <= wr.lnk_to;
		end
	end

	// Slot flags and the occupancy count are kept exact at every edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			lv_q   <= '0;
			size_q <= '0;
		end else begin
			if (wr.set_en) begin
				used_q[wr.set_addr] <= 1'b1;
				lv_q[wr.set_addr]   <= 1'b0;
				if (!used_q[wr.set_addr]) begin
					size_q <= size_q + cnt_t'(1);
				end
			end
			if (wr.lnk_en) begin
				lv_q[wr.lnk_addr] <= 1'b1;
			end
			if (wr.clr_en) begin
				used_q[wr.clr_addr] <= 1'b0;
				lv_q[wr.clr_addr]   <= 1'b0;
				if (used_q[wr.clr_addr]) begin
					size_q <= size_q - cnt_t'(1);
				end
			end
			if (wr.cut_en) begin
				lv_q[wr.cut_addr] <= 1'b0;
			end
		end
	end

	always_comb begin
		rd.used     = used_q[rd_addr];
		rd.has_next = lv_q[rd_addr];
		rd.link     = link_mem[rd_addr];
		rd.value    = value_mem[rd_addr];
	end

	assign used = used_q;
	assign size = size_q;

endmodule

@@ rtl/coalesced_hash_multiset_unit.sv @@
// Coalesced-chaining multiset of 32-bit signed words in a 16-slot table.
// A command word (cmd, value) is taken at a rising edge with start high and
// busy low. Insert, remove one occurrence and count occurrences are
// supported; cmd 3 changes nothing. Every command returns exactly one result
// word: status, occurrences, stored_count and is_empty appear together with
// done high for a single cycle, and busy drops in the following cycle.
// The receiver cannot stall; it must take the result in that cycle.
// All work runs through one slot-table read port under a small sequencer
// that visits at most one slot per cycle. Count and a missed remove walk
// the chain from the home slot. Insert takes the home slot if free, else
// walks the chain and links in the lowest free slot, then scans forward
// for the next free slot. A hit on remove walks, collects and clears the
// tail of the chain and then reinserts each follower. Reset clears the
// used and link flags, the count and the lowest-free pointer at once, so
// a command may start right after reset.
module coalesced_hash_multiset_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   cmd,
	input  logic [31:0]  value,
	output logic         done,
	output logic [1:0]   status,
	output logic [4:0]   occurrences,
	output logic [4:0]   stored_count,
	output logic         is_empty
);
	import chm_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_INS_HOME = 11'b00000000010,
		S_INS_WALK = 11'b00000000100,
		S_INS_ADV  = 11'b00000001000,
		S_REM_FIND = 11'b00000010000,
		S_COL_STEP = 11'b00000100000,
		S_COL_SAVE = 11'b00001000000,
		S_REM_CLR  = 11'b00010000000,
		S_REM_REIN = 11'b00100000000,
		S_CNT_WALK = 11'b01000000000,
		S_DONE     = 11'b10000000000
	} state_t;

	localparam cnt_t CAP_C = cnt_t'(CAPACITY);

	state_t  state_q;
	word_t   val_q;      // operand of the command
	word_t   ins_val_q;  // word being inserted (command or follower)
	logic    ret_q;      // insert runs on behalf of a remove
	idx_t    ptr_q;      // slot under visit
	idx_t    cur_q;      // slot of the matched word on remove
	idx_t    prev_q;
	logic    has_prev_q;
	cnt_t    steps_q;
	cnt_t    cnt_q;      // followers held in the buffer
	cnt_t    k_q;
	cnt_t    lf_q;       // lowest free slot, CAPACITY when full
	cnt_t    occ_q;
	status_t status_q;
	word_t   buf_mem [CAPACITY];

	rd_t   rd;
	wr_t   wr;
	idx_t  rd_addr;
	idx_t  ins_home;
	logic [CAPACITY-1:0] used;
	cnt_t  size;

	logic lf_ok;
	logic walk_more;
	logic match;
	logic clr_last;
	idx_t lf_idx;

	chm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd      (rd),
		.used    (used),
		.wr      (wr),
		.size    (size)
	);

	assign ins_home  = home_of(ins_val_q);
	assign lf_idx    = lf_q[IDX_W-1:0];
	assign lf_ok     = lf_q < CAP_C;
	assign walk_more = rd.has_next && (steps_q < CAP_C);
	assign match     = rd.used && (rd.value == val_q);
	assign clr_last  = !rd.has_next || (k_q == cnt_q);
	assign rd_addr   = (state_q == S_INS_HOME) ? ins_home : ptr_q;

	always_comb begin
		wr = '0;
		case (state_q)
			S_INS_HOME: begin
				if (lf_ok && !rd.used) begin
					wr.set_en    = 1'b1;
					wr.set_addr  = ins_home;
					wr.set_value = ins_val_q;
				end
			end
			S_INS_WALK: begin
				if (!walk_more) begin
					wr.set_en    = 1'b1;
					wr.set_addr  = lf_idx;
					wr.set_value = ins_val_q;
					wr.lnk_en    = 1'b1;
					wr.lnk_addr  = ptr_q;
					wr.lnk_to    = lf_idx;
				end
			end
			S_REM_CLR: begin
				wr.clr_en   = 1'b1;
				wr.clr_addr = ptr_q;
				if (clr_last && has_prev_q) begin
					wr.cut_en   = 1'b1;
					wr.cut_addr = prev_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COL_SAVE) begin
			buf_mem[cnt_q[IDX_W-1:0]] <= rd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			val_q      <= '0;
			ins_val_q  <= '0;
			ret_q      <= 1'b0;
			ptr_q      <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
			has_prev_q <= 1'b0;
			steps_q    <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			lf_q       <= '0;
			occ_q      <= '0;
			status_q   <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q      <= value;
						ins_val_q  <= value;
						ret_q      <= 1'b0;
						ptr_q      <= home_of(value);
						steps_q    <= '0;
						has_prev_q <= 1'b0;
						occ_q      <= '0;
						status_q   <= ST_OK;
						case (cmd)
							CMD_INSERT: state_q <= S_INS_HOME;
							CMD_REMOVE: state_q <= S_REM_FIND;
							CMD_COUNT:  state_q <= S_CNT_WALK;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_INS_HOME: begin
					if (!lf_ok) begin
						if (!ret_q) begin
							status_q <= ST_FULL;
						end
						state_q <= ret_q ? S_REM_REIN : S_DONE;
					end else if (!rd.used) begin
						if (ins_home == lf_idx) begin
							lf_q    <= lf_q + cnt_t'(1);
							state_q <= S_INS_ADV;
						end else begin
							state_q <= ret_q ? S_REM_REIN : S_DONE;
						end
					end else begin
						ptr_q   <= ins_home;
						steps_q <= '0;
						state_q <= S_INS_WALK;
					end
				end
				S_INS_WALK: begin
					if (walk_more) begin
						ptr_q   <= rd.link;
						steps_q <= steps_q + cnt_t'(1);
					end else begin
						lf_q    <= lf_q + cnt_t'(1);
						state_q <= S_INS_ADV;
					end
				end
				S_INS_ADV: begin
					if (lf_ok && used[lf_idx]) begin
						lf_q <= lf_q + cnt_t'(1);
					end else begin
						state_q <= ret_q ? S_REM_REIN : S_DONE;
					end
				end
				S_REM_FIND: begin
					if (steps_q == CAP_C) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else if (match) begin
						cur_q   <= ptr_q;
						cnt_q   <= '0;
						state_q <= S_COL_STEP;
					end else if (!rd.has_next) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						prev_q     <= ptr_q;
						has_prev_q <= 1'b1;
						ptr_q      <= rd.link;
						steps_q    <= steps_q + cnt_t'(1);
					end
				end
				S_COL_STEP: begin
					if (rd.has_next && (cnt_q < CAP_C)) begin
						ptr_q   <= rd.link;
						state_q <= S_COL_SAVE;
					end else begin
						ptr_q   <= cur_q;
						k_q     <= '0;
						state_q <= S_REM_CLR;
					end
				end
				S_COL_SAVE: begin
					cnt_q   <= cnt_q + cnt_t'(1);
					state_q <= S_COL_STEP;
				end
				S_REM_CLR: begin
					if ({1'b0, ptr_q} < lf_q) begin
						lf_q <= cnt_t'(ptr_q);
					end
					if (clr_last) begin
						k_q     <= '0;
						state_q <= S_REM_REIN;
					end else begin
						ptr_q <= rd.link;
						k_q   <= k_q + cnt_t'(1);
					end
				end
				S_REM_REIN: begin
					if (k_q < cnt_q) begin
						ins_val_q <= buf_mem[k_q[IDX_W-1:0]];
						k_q       <= k_q + cnt_t'(1);
						ret_q     <= 1'b1;
						state_q   <= S_INS_HOME;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CNT_WALK: begin
					if (steps_q == CAP_C) begin
						state_q <= S_DONE;
					end else begin
						if (match) begin
							occ_q <= occ_q + cnt_t'(1);
						end
						if (!rd.has_next) begin
							state_q <= S_DONE;
						end else begin
							ptr_q   <= rd.link;
							steps_q <= steps_q + cnt_t'(1);
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_DONE);
	assign status       = status_q;
	assign occurrences  = 5'(occ_q);
	assign stored_count = 5'(size);
	assign is_empty     = (size == '0);

	// The lowest-free pointer never runs past the full mark.
	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		lf_q <= CAP_C)
		else $error("lowest free pointer out of range");

	// The occupancy count never exceeds the table size.
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		size <= CAP_C)
		else $error("occupancy count out of range");

	// Every command ends with exactly one result word before busy drops.
	a_done_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// A full status is only reported while the table is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (lf_q == CAP_C))
		else $error("full status with a free slot");

	// Followers never exceed the table size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("follower count out of range");

endmodule
